// ===== hdl/qcmd_pkg.sv =====
// Shared constants, types and reset values for the constellation mapper and demapper.
// Used by qcmd_point_mem, qcmd_dist and qam_constellation_map_demap.
// Depends on nothing else.
package qcmd_pkg;

  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned COORD_BITS = 12;

  localparam int unsigned PT_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W     = PT_W + 1;
  localparam int unsigned NUM_PAIRS = 4;
  localparam int unsigned PAIR_AW   = 2;
  localparam int unsigned POINT_W   = 2 * COORD_BITS;
  localparam int unsigned PAIR_W    = 2 * POINT_W;
  localparam int unsigned DIFF_W    = COORD_BITS + 1;
  localparam int unsigned SQ_W      = 2 * COORD_BITS + 1;
  localparam int unsigned DIST_W    = SQ_W + 1;
  localparam int unsigned PC_W      = 4;

  localparam int unsigned IN_FIELDS_W  = 3 + 2 * COORD_BITS;
  localparam int unsigned TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_PAIR_0      = 3'd1,
    REG_PAIR_1      = 3'd2,
    REG_PAIR_2      = 3'd3,
    REG_PAIR_3      = 3'd4
  } cfg_reg_e;

  localparam logic [PC_W-1:0] POINT_COUNT_RESET = 4'd8;

  localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
    48'd96138547956361,
    48'd185336428758391,
    48'd35192964124160,
    48'd246350748844544
  };

  typedef struct packed {
    logic                         valid;
    logic [PT_W-1:0]              idx;
    logic signed [COORD_BITS-1:0] re;
    logic signed [COORD_BITS-1:0] im;
    logic [DIST_W-1:0]            sq_dist;
  } cand_t;

endpackage

// ===== hdl/qcmd_point_mem.sv =====
// Point-pair memory: four entries of two packed points, one write and one read port.
// Read data is registered; entries not yet written read as their reset pair.
// Depends on qcmd_pkg.
module qcmd_point_mem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [qcmd_pkg::PAIR_AW-1:0]        waddr_i,
  input  logic [qcmd_pkg::PAIR_W-1:0]         wdata_i,
  input  logic                                re_i,
  input  logic [qcmd_pkg::PAIR_AW-1:0]        raddr_i,
  output logic [qcmd_pkg::PAIR_W-1:0]         rdata_o
);

  logic [qcmd_pkg::PAIR_W-1:0]    mem_q [qcmd_pkg::NUM_PAIRS];
  logic [qcmd_pkg::NUM_PAIRS-1:0] valid_q;
  logic [qcmd_pkg::PAIR_W-1:0]    rd_q;
  logic                           rd_valid_q;
  logic [qcmd_pkg::PAIR_AW-1:0]   rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
        rd_addr_q  <= raddr_i;
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : qcmd_pkg::PAIR_RESET[rd_addr_q];

endmodule

// ===== hdl/qcmd_dist.sv =====
// Distance stage: picks one point from a pair, subtracts it from the sample and
// registers both squared differences; the sum of the squares is the candidate distance.
// Depends on qcmd_pkg.
module qcmd_dist (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [qcmd_pkg::PT_W-1:0]              idx_i,
  input  logic [qcmd_pkg::PAIR_W-1:0]            pair_i,
  input  logic signed [qcmd_pkg::COORD_BITS-1:0] rx_re_i,
  input  logic signed [qcmd_pkg::COORD_BITS-1:0] rx_im_i,
  output qcmd_pkg::cand_t                        cand_o
);

  localparam int unsigned C = qcmd_pkg::COORD_BITS;

  logic [qcmd_pkg::POINT_W-1:0]          point;
  logic signed [C-1:0]                   pt_re;
  logic signed [C-1:0]                   pt_im;
  logic signed [qcmd_pkg::DIFF_W-1:0]    diff_re;
  logic signed [qcmd_pkg::DIFF_W-1:0]    diff_im;
  logic signed [2*qcmd_pkg::DIFF_W-1:0]  prod_re;
  logic signed [2*qcmd_pkg::DIFF_W-1:0]  prod_im;

  logic                                  valid_q;
  logic [qcmd_pkg::PT_W-1:0]             idx_q;
  logic signed [C-1:0]                   re_q;
  logic signed [C-1:0]                   im_q;
  logic [qcmd_pkg::SQ_W-1:0]             sq_re_q;
  logic [qcmd_pkg::SQ_W-1:0]             sq_im_q;

  always_comb begin
    point   = idx_i[0] ? pair_i[qcmd_pkg::PAIR_W-1:qcmd_pkg::POINT_W]
                       : pair_i[qcmd_pkg::POINT_W-1:0];
    pt_re   = point[C-1:0];
    pt_im   = point[2*C-1:C];
    diff_re = {rx_re_i[C-1], rx_re_i} - {pt_re[C-1], pt_re};
    diff_im = {rx_im_i[C-1], rx_im_i} - {pt_im[C-1], pt_im};
    prod_re = diff_re * diff_re;
    prod_im = diff_im * diff_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      idx_q   <= idx_i;
      re_q    <= pt_re;
      im_q    <= pt_im;
      sq_re_q <= prod_re[qcmd_pkg::SQ_W-1:0];
      sq_im_q <= prod_im[qcmd_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    cand_o.valid   = valid_q;
    cand_o.idx     = idx_q;
    cand_o.re      = re_q;
    cand_o.im      = im_q;
    cand_o.sq_dist = {1'b0, sq_re_q} + {1'b0, sq_im_q};
  end

endmodule

// ===== hdl/qam_constellation_map_demap.sv =====
// Constellation mapper and minimum-distance demapper, top level.
// Instantiates qcmd_point_mem and qcmd_dist; depends on qcmd_pkg.
//
// Input items arrive on the s_axis channel: tuser carries the mode (0 map,
// 1 demap), tdata the symbol index and the received I/Q sample. Each item
// gives one result item on the m_axis channel: tdata holds the index and
// the point's coordinates, tuser the bad-index flag.
// The constellation sits in a four-entry pair memory with one read port,
// so the sequencer reads one point per cycle. A demap item searches the
// number of points configured (one to eight), a map item reads only its own
// point, and a bad map index reads no point at all.
// One item is in work at a time; s_axis_tready is high only while the
// sequencer idles, so the next item is taken at the earliest in the cycle after
// the output register is loaded. A new item may be accepted while the
// previous result waits; if the receiver stalls, a finished result waits
// for the output register to empty before the next item is taken.
// Reset clears the control state, sets the point count to eight and makes
// every pair read as its 8-QAM default until it is first written.
// Configuration writes are taken at any edge with cfg_we_i high.
module qam_constellation_map_demap (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // symbol_index, rx_real, rx_imag, zero fill
  input  logic [qcmd_pkg::TDATA_W-1:0]          s_axis_tdata,
  // mode
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // found_index, point_real, point_imag, zero fill
  output logic [qcmd_pkg::TDATA_W-1:0]          m_axis_tdata,
  // bad_index
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [qcmd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [qcmd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned C = qcmd_pkg::COORD_BITS;
  localparam int unsigned PT_W = qcmd_pkg::PT_W;
  localparam int unsigned CNT_W = qcmd_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [qcmd_pkg::PC_W-1:0] point_count_q;
  logic [CNT_W-1:0]          n_use;
  logic [CNT_W-1:0]          n_search;

  logic [CNT_W-1:0]          issue_q, issue_d;
  logic [CNT_W-1:0]          end_q, end_d;
  logic                      issuing;
  logic                      rd_v_q;
  logic [PT_W-1:0]           rd_idx_q;
  logic signed [C-1:0]       rx_re_q;
  logic signed [C-1:0]       rx_im_q;

  logic                      have_best_q;
  logic [qcmd_pkg::DIST_W-1:0] best_dist_q;
  logic [PT_W-1:0]           best_idx_q;
  logic signed [C-1:0]       best_re_q;
  logic signed [C-1:0]       best_im_q;
  logic                      bad_q;

  logic                      out_valid_q;
  logic [PT_W-1:0]           out_idx_q;
  logic signed [C-1:0]       out_re_q;
  logic signed [C-1:0]       out_im_q;
  logic                      out_bad_q;

  logic                      in_acc;
  logic                      out_load;
  logic                      take_cand;
  logic                      in_mode;
  logic [PT_W-1:0]           in_sym;
  logic                      in_bad;

  logic [qcmd_pkg::PAIR_W-1:0] rdata;
  qcmd_pkg::cand_t           cand;

  logic                      pair_we;
  logic [qcmd_pkg::PAIR_AW-1:0] pair_waddr;

  // Configuration decode.
  always_comb begin
    pair_we    = 1'b0;
    pair_waddr = '0;
    unique case (cfg_idx_i)
      qcmd_pkg::REG_PAIR_0: begin
        pair_we    = cfg_we_i;
        pair_waddr = 2'd0;
      end
      qcmd_pkg::REG_PAIR_1: begin
        pair_we    = cfg_we_i;
        pair_waddr = 2'd1;
      end
      qcmd_pkg::REG_PAIR_2: begin
        pair_we    = cfg_we_i;
        pair_waddr = 2'd2;
      end
      qcmd_pkg::REG_PAIR_3: begin
        pair_we    = cfg_we_i;
        pair_waddr = 2'd3;
      end
      default: begin
        pair_we    = 1'b0;
        pair_waddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= qcmd_pkg::POINT_COUNT_RESET;
    end else if (cfg_we_i && cfg_idx_i == qcmd_pkg::REG_POINT_COUNT) begin
      point_count_q <= cfg_data_i[qcmd_pkg::PC_W-1:0];
    end
  end

  always_comb begin
    if (point_count_q > CNT_W'(qcmd_pkg::MAX_POINTS)) begin
      n_use = CNT_W'(qcmd_pkg::MAX_POINTS);
    end else begin
      n_use = point_count_q[CNT_W-1:0];
    end
    n_search = (n_use == '0) ? CNT_W'(1) : n_use;
  end

  qcmd_point_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pair_we),
    .waddr_i (pair_waddr),
    .wdata_i (cfg_data_i[qcmd_pkg::PAIR_W-1:0]),
    .re_i    (issuing),
    .raddr_i (issue_q[PT_W-1:1]),
    .rdata_o (rdata)
  );

  qcmd_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .idx_i   (rd_idx_q),
    .pair_i  (rdata),
    .rx_re_i (rx_re_q),
    .rx_im_i (rx_im_q),
    .cand_o  (cand)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser;
  assign in_sym        = s_axis_tdata[PT_W-1:0];
  assign in_bad        = !in_mode && ({1'b0, in_sym} >= n_use);
  assign issuing       = (state_q == S_RUN) && (issue_q != end_q);
  assign take_cand     = cand.valid && (!have_best_q || cand.sq_dist < best_dist_q);
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    end_d   = end_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RUN;
          if (in_mode) begin
            issue_d = '0;
            end_d   = n_search;
          end else begin
            issue_d = {1'b0, in_sym};
            end_d   = in_bad ? {1'b0, in_sym} : {1'b0, in_sym} + CNT_W'(1);
          end
        end
      end
      S_RUN: begin
        if (issuing) begin
          issue_d = issue_q + CNT_W'(1);
        end else if (!rd_v_q && !cand.valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      end_q       <= '0;
      rd_v_q      <= 1'b0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      end_q   <= end_d;
      rd_v_q  <= issuing;
      if (in_acc) begin
        have_best_q <= 1'b0;
      end else if (take_cand) begin
        have_best_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issuing) begin
      rd_idx_q <= issue_q[PT_W-1:0];
    end
    if (in_acc) begin
      rx_re_q    <= s_axis_tdata[PT_W+C-1:PT_W];
      rx_im_q    <= s_axis_tdata[PT_W+2*C-1:PT_W+C];
      best_idx_q <= in_mode ? '0 : in_sym;
      best_re_q  <= '0;
      best_im_q  <= '0;
      bad_q      <= in_bad;
    end else if (take_cand) begin
      best_dist_q <= cand.sq_dist;
      best_idx_q  <= cand.idx;
      best_re_q   <= cand.re;
      best_im_q   <= cand.im;
    end
    if (out_load) begin
      out_idx_q <= best_idx_q;
      out_re_q  <= best_re_q;
      out_im_q  <= best_im_q;
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(qcmd_pkg::TDATA_W - qcmd_pkg::IN_FIELDS_W){1'b0}},
                          out_im_q, out_re_q, out_idx_q};
  assign m_axis_tuser  = out_bad_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!rd_v_q && !cand.valid))
    else $error("Point pipeline busy while a new item can be accepted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_re_q == '0 && out_im_q == '0))
    else $error("Bad index result carries non-zero coordinates.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (issue_q <= end_q && end_q <= CNT_W'(qcmd_pkg::MAX_POINTS)))
    else $error("Point counter ran past the end of the search.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (!rd_v_q && !cand.valid))
    else $error("Result completed before the last point was compared.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (bad_q || have_best_q))
    else $error("Result loaded without any point compared.");

endmodule

// ===== tb/qam_constellation_map_demap_test.sv =====
// Self-checking testbench for the constellation mapper and demapper.
// It streams map and demap items through several constellations and checks
// every result against its own model (nearest point for demap). Depends on qcmd_pkg.
module qam_constellation_map_demap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POINTS = qcmd_pkg::MAX_POINTS;
  localparam int unsigned PT_W       = qcmd_pkg::PT_W;
  localparam int unsigned NUM_PAIRS  = qcmd_pkg::NUM_PAIRS;
  localparam int unsigned POINT_W    = qcmd_pkg::POINT_W;
  localparam int unsigned PAIR_W     = qcmd_pkg::PAIR_W;
  localparam int unsigned PC_W       = qcmd_pkg::PC_W;
  localparam int unsigned TDATA_W    = qcmd_pkg::TDATA_W;
  localparam int unsigned CFG_IDX_W  = qcmd_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = qcmd_pkg::CFG_DATA_W;

  localparam int CW          = qcmd_pkg::COORD_BITS;
  localparam int COORD_MAX   = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN   = -(2 ** (CW - 1));
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 140;

  localparam logic MODE_MAP   = 1'b0;
  localparam logic MODE_DEMAP = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [PT_W-1:0]      sym;
    logic signed [CW-1:0] rx_re;
    logic signed [CW-1:0] rx_im;
  } symbol_t;

  typedef struct packed {
    logic [PT_W-1:0]      idx;
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
    logic                 bad;
  } point_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  logic [PC_W-1:0]   count_cfg = 4'd8;
  logic [PAIR_W-1:0] pair_cfg [NUM_PAIRS] = '{
    48'd96138547956361, 48'd185336428758391, 48'd35192964124160, 48'd246350748844544
  };

  symbol_t     pending_symbols [$];
  point_t      expected_points [$];
  int unsigned symbols_queued = 0;
  int unsigned points_seen    = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  logic        in_taken       = 1'b0;
  logic        calm           = 1'b0;

  qam_constellation_map_demap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void point_at(input int unsigned i, output logic signed [CW-1:0] re,
                                   output logic signed [CW-1:0] im);
    logic [PAIR_W-1:0]  pair;
    logic [POINT_W-1:0] pt;
    pair = pair_cfg[(i / 2) % NUM_PAIRS];
    pt   = (i % 2 == 1) ? pair[PAIR_W-1:POINT_W] : pair[POINT_W-1:0];
    re   = pt[CW-1:0];
    im   = pt[POINT_W-1:CW];
  endfunction

  function automatic point_t lookup_point(input symbol_t s);
    point_t               r;
    int unsigned          n;
    int unsigned          i;
    logic signed [CW-1:0] pr;
    logic signed [CW-1:0] pi;
    int                   dr;
    int                   di;
    int                   d;
    int                   best;
    r    = '0;
    best = 0;
    n    = (count_cfg > MAX_POINTS) ? MAX_POINTS : count_cfg;
    if (s.mode == MODE_MAP) begin
      r.idx = s.sym;
      if (s.sym >= n) begin
        r.bad = 1'b1;
      end else begin
        point_at(s.sym, pr, pi);
        r.re = pr;
        r.im = pi;
      end
    end else begin
      for (i = 0; i < ((n == 0) ? 1 : n); i++) begin
        point_at(i, pr, pi);
        dr = s.rx_re - pr;
        di = s.rx_im - pi;
        d  = dr * dr + di * di;
        if (i == 0 || d < best) begin
          best  = d;
          r.idx = PT_W'(i);
          r.re  = pr;
          r.im  = pi;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] jitter(input logic signed [CW-1:0] c);
    int v;
    v = c + int'($urandom_range(0, 96)) - 48;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return CW'(v);
  endfunction

  function automatic symbol_t random_symbol();
    symbol_t              s;
    logic signed [CW-1:0] pr;
    logic signed [CW-1:0] pi;
    s.mode  = ($urandom_range(0, 1) == 0) ? MODE_MAP : MODE_DEMAP;
    s.sym   = PT_W'($urandom_range(0, MAX_POINTS - 1));
    s.rx_re = CW'($urandom);
    s.rx_im = CW'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      point_at($urandom_range(0, MAX_POINTS - 1), pr, pi);
      s.rx_re = jitter(pr);
      s.rx_im = jitter(pi);
    end
    return s;
  endfunction

  task automatic queue_symbol(input symbol_t s);
    pending_symbols.push_back(s);
    symbols_queued++;
  endtask

  task automatic map_symbol(input int unsigned idx);
    symbol_t s;
    s       = '0;
    s.mode  = MODE_MAP;
    s.sym   = PT_W'(idx);
    queue_symbol(s);
  endtask

  task automatic demap_sample(input int re, input int im);
    symbol_t s;
    s       = '0;
    s.mode  = MODE_DEMAP;
    s.rx_re = CW'(re);
    s.rx_im = CW'(im);
    queue_symbol(s);
  endtask

  task automatic drain();
    while (points_seen < symbols_queued) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input qcmd_pkg::cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      qcmd_pkg::REG_POINT_COUNT: count_cfg   = val[PC_W-1:0];
      qcmd_pkg::REG_PAIR_0:      pair_cfg[0] = val[PAIR_W-1:0];
      qcmd_pkg::REG_PAIR_1:      pair_cfg[1] = val[PAIR_W-1:0];
      qcmd_pkg::REG_PAIR_2:      pair_cfg[2] = val[PAIR_W-1:0];
      qcmd_pkg::REG_PAIR_3:      pair_cfg[3] = val[PAIR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_constellation(input logic [PC_W-1:0] cnt, input logic [PAIR_W-1:0] p0,
                                    input logic [PAIR_W-1:0] p1, input logic [PAIR_W-1:0] p2,
                                    input logic [PAIR_W-1:0] p3);
    drain();
    write_reg(qcmd_pkg::REG_POINT_COUNT, CFG_DATA_W'(cnt));
    write_reg(qcmd_pkg::REG_PAIR_0, p0);
    write_reg(qcmd_pkg::REG_PAIR_1, p1);
    write_reg(qcmd_pkg::REG_PAIR_2, p2);
    write_reg(qcmd_pkg::REG_PAIR_3, p3);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: a new item is presented only once the previous one has been taken.
  always @(negedge clk_i) begin
    symbol_t s;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_symbols.size() > 0) begin
        s = pending_symbols.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.mode;
        s_axis_tdata  <= {{(TDATA_W - PT_W - 2 * CW){1'b0}}, s.rx_im, s.rx_re, s.sym};
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    symbol_t s;
    point_t  got;
    point_t  want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got.idx = m_axis_tdata[PT_W-1:0];
      got.re  = m_axis_tdata[PT_W +: CW];
      got.im  = m_axis_tdata[PT_W + CW +: CW];
      got.bad = m_axis_tuser;
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result idx %0d re %0d im %0d bad %0b",
                 $time, got.idx, got.re, got.im, got.bad);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: found_index expected %0d actual %0d", $time, want.idx, got.idx);
          mismatches++;
        end
        if (got.re !== want.re) begin
          $display("%0t: point_real expected %0d actual %0d", $time, want.re, got.re);
          mismatches++;
        end
        if (got.im !== want.im) begin
          $display("%0t: point_imag expected %0d actual %0d", $time, want.im, got.im);
          mismatches++;
        end
        if (got.bad !== want.bad) begin
          $display("%0t: bad_index expected %0b actual %0b", $time, want.bad, got.bad);
          mismatches++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s.mode  = s_axis_tuser;
      s.sym   = s_axis_tdata[PT_W-1:0];
      s.rx_re = s_axis_tdata[PT_W +: CW];
      s.rx_im = s_axis_tdata[PT_W + CW +: CW];
      expected_points.push_back(lookup_point(s));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [PC_W-1:0]   cnt;
    logic [PAIR_W-1:0] p [NUM_PAIRS];
    int unsigned       r;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default 8-QAM constellation straight out of reset; the origin is a four-way tie.
    for (int unsigned i = 0; i < MAX_POINTS; i++) map_symbol(i);
    demap_sample(0, 0);
    demap_sample(1399, 0);
    demap_sample(COORD_MIN, COORD_MIN);
    demap_sample(COORD_MAX, COORD_MAX);
    demap_sample(COORD_MIN, COORD_MAX);
    demap_sample(COORD_MAX, COORD_MIN);

    load_constellation(4'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h8007FF_7FF800, 48'h7FF7FF_800800);
    map_symbol(0);
    map_symbol(7);
    demap_sample(COORD_MAX, COORD_MAX);

    load_constellation(4'd15, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h8007FF_7FF800,
                       48'h7FF7FF_800800);
    map_symbol(7);
    map_symbol(0);
    demap_sample(COORD_MAX, COORD_MAX);
    demap_sample(COORD_MIN, COORD_MIN);
    demap_sample(0, 0);

    load_constellation(4'd1, 48'h123456_7FF800, 48'h0, 48'h0, 48'h0);
    map_symbol(1);
    map_symbol(0);
    demap_sample(COORD_MAX, COORD_MAX);

    for (int unsigned ph = 0; ph < 7; ph++) begin
      if (ph == 0) begin
        load_constellation(4'd8, 48'd96138547956361, 48'd185336428758391,
                           48'd35192964124160, 48'd246350748844544);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4) cnt = 4'd8;
        else if (r < 7) cnt = 4'd4;
        else cnt = PC_W'($urandom_range(0, 15));
        for (int unsigned k = 0; k < NUM_PAIRS; k++) p[k] = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 3) == 0) p[3] = p[0];
        load_constellation(cnt, p[0], p[1], p[2], p[3]);
      end
      calm = (ph == 3);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) queue_symbol(random_symbol());
      drain();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
